/* rtl/fsms_pkg.sv */
package fsms_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int MAX_TEXT    = 4096;

  localparam int PAT_AW = $clog2(MAX_PATTERN);
  localparam int TXT_AW = $clog2(MAX_TEXT);
  localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
  localparam int TLEN_W = $clog2(MAX_TEXT + 1);
  localparam int POS_W  = 12;
  localparam int SYM_W  = 8;

endpackage

/* rtl/fsms_ram.sv */
module fsms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/first_substring_match_search.sv */
// Loading: one request per cycle while idle; a pattern or text byte is written that cycle.
// Search starts on the final text request; the input stalls until the result is taken.
// Each compared byte pair is handled by a memory read state, then a compare state.
// Synchronous active-high reset clears lengths, flags and the result; stores stay
// undefined until written.
module first_substring_match_search
  import fsms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             kind,
  input  logic [SYM_W-1:0] symbol,
  input  logic             has_symbol,
  input  logic             final_item,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             found,
  output logic [POS_W-1:0] position,
  output logic             overflow
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state;
  logic [PLEN_W-1:0] plen;
  logic              pclosed;
  logic [TLEN_W-1:0] tlen;
  logic              ovf;
  logic [TLEN_W-1:0] start;
  logic [PLEN_W-1:0] k;

  logic              accept;
  logic              pat_room;
  logic              txt_room;
  logic              pat_we;
  logic              txt_we;
  logic              ovf_hit;
  logic [TLEN_W-1:0] tlen_next;
  logic [TLEN_W-1:0] tidx;
  logic [PLEN_W-1:0] k_inc;
  logic [TLEN_W-1:0] start_inc;
  logic [TLEN_W:0]   span_end;
  logic [SYM_W-1:0]  pat_q;
  logic [SYM_W-1:0]  txt_q;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);
  assign overflow  = ovf;

  assign pat_room  = (plen < PLEN_W'(MAX_PATTERN));
  assign txt_room  = (tlen < TLEN_W'(MAX_TEXT));
  assign pat_we    = accept && !kind && !pclosed && has_symbol && pat_room;
  assign txt_we    = accept && kind && has_symbol && txt_room;
  assign ovf_hit   = accept && has_symbol &&
                     ((!kind && !pclosed && !pat_room) || (kind && !txt_room));
  assign tlen_next = txt_we ? tlen + TLEN_W'(1) : tlen;

  assign tidx      = start + TLEN_W'(k);
  assign k_inc     = k + PLEN_W'(1);
  assign start_inc = start + TLEN_W'(1);
  assign span_end  = (TLEN_W+1)'(start_inc) + (TLEN_W+1)'(plen);

  fsms_ram #(
    .WIDTH(SYM_W),
    .DEPTH(MAX_PATTERN)
  ) u_pat_ram (
    .clk  (clk),
    .we   (pat_we),
    .waddr(plen[PAT_AW-1:0]),
    .wdata(symbol),
    .raddr(k[PAT_AW-1:0]),
    .rdata(pat_q)
  );

  fsms_ram #(
    .WIDTH(SYM_W),
    .DEPTH(MAX_TEXT)
  ) u_txt_ram (
    .clk  (clk),
    .we   (txt_we),
    .waddr(tlen[TXT_AW-1:0]),
    .wdata(symbol),
    .raddr(tidx[TXT_AW-1:0]),
    .rdata(txt_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      plen     <= '0;
      pclosed  <= 1'b0;
      tlen     <= '0;
      ovf      <= 1'b0;
      found    <= 1'b0;
      position <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (pat_we) begin
              plen <= plen + PLEN_W'(1);
            end
            if (!kind && !pclosed && final_item) begin
              pclosed <= 1'b1;
            end
            tlen <= tlen_next;
            if (ovf_hit) begin
              ovf <= 1'b1;
            end
            if (kind && final_item) begin
              start <= '0;
              k     <= '0;
              if (TLEN_W'(plen) > tlen_next) begin
                found    <= 1'b0;
                position <= '0;
                state    <= S_DONE;
              end else if (plen == '0) begin
                found    <= 1'b1;
                position <= '0;
                state    <= S_DONE;
              end else begin
                state <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (pat_q == txt_q) begin
            if (k_inc == plen) begin
              found    <= 1'b1;
              position <= start[POS_W-1:0];
              state    <= S_DONE;
            end else begin
              k     <= k_inc;
              state <= S_READ;
            end
          end else if (span_end > {1'b0, tlen}) begin
            found    <= 1'b0;
            position <= '0;
            state    <= S_DONE;
          end else begin
            start <= start_inc;
            k     <= '0;
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            plen    <= '0;
            pclosed <= 1'b0;
            tlen    <= '0;
            ovf     <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_request_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted while a result is pending");

  a_index_in_pattern: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (k < plen))
    else $error("pattern index beyond pattern length");

  a_match_fits_text: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |->
      ((TLEN_W+1)'(position) + (TLEN_W+1)'(plen) <= {1'b0, tlen}))
    else $error("reported match runs past the text");

  a_read_then_compare: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_CMP))
    else $error("compare did not follow memory read");

endmodule
